// ----- rtl/dqip_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the dotted-quad IPv4 text parser.
// No dependencies; every other file in rtl/ refers to this package by scoped name.
package dqip_pkg;

  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [8:0] SegSat     = 9'd256;
  localparam logic [8:0] OctetMax   = 9'd255;
  localparam logic [2:0] OctetCount = 3'd4;

  typedef enum logic [1:0] {
    PhSpace,
    PhDigits,
    PhStop
  } phase_e;

  typedef struct packed {
    logic [2:0]  octets_done;
    logic        error_seen;
    logic [23:0] octets_so_far;
    logic [8:0]  segment_value;
    logic        segment_nonempty;
    phase_e      number_phase;
    logic        segment_negative;
  } state_t;

  localparam state_t StateReset = '{
    octets_done:      3'd0,
    error_seen:       1'b0,
    octets_so_far:    24'd0,
    segment_value:    9'd0,
    segment_nonempty: 1'b0,
    number_phase:     PhSpace,
    segment_negative: 1'b0
  };

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] address;
  } out_item_t;

endpackage

// ----- rtl/dqip_in_reg.sv -----
`timescale 1ns / 1ps
// Input register stage of the dotted-quad IPv4 parser.
// Depends on dqip_pkg for the input transaction type.
module dqip_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  dqip_pkg::in_item_t in_data_i,
  input  logic             advance_i,
  output logic             held_valid_o,
  output dqip_pkg::in_item_t held_data_o
);

  logic               vld_q, vld_d;
  dqip_pkg::in_item_t data_q;
  logic               take;

  // Hold the current transaction until the core consumes it.
  assign in_stall_o = vld_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= in_data_i;
    end
  end

  assign held_valid_o = vld_q;
  assign held_data_o  = data_q;

endmodule

// ----- rtl/dqip_step.sv -----
`timescale 1ns / 1ps
// Next-state logic for one character of the dotted-quad IPv4 parser.
// Depends on dqip_pkg for the parser state type and character constants.
module dqip_step (
  input  dqip_pkg::state_t st_i,
  input  logic [7:0]       char_i,
  input  logic             last_i,
  output dqip_pkg::state_t st_o,
  output logic             done_o,
  output logic [31:0]      addr_o
);

  logic             is_dot;
  logic             is_digit;
  logic             is_space;
  logic             is_sign;
  logic [11:0]      acc;
  logic [8:0]       acc_sat;
  dqip_pkg::state_t nx;

  assign is_dot   = (char_i == dqip_pkg::CharDot);
  assign is_digit = (char_i >= dqip_pkg::CharZero) && (char_i <= dqip_pkg::CharNine);
  assign is_space = (char_i == dqip_pkg::CharSpace) ||
                    ((char_i >= dqip_pkg::CharTab) && (char_i <= dqip_pkg::CharCr));
  assign is_sign  = (char_i == dqip_pkg::CharPlus) || (char_i == dqip_pkg::CharMinus);

  // Multiply-by-ten accumulate; the digit is the low nibble of its code.
  assign acc     = 12'(st_i.segment_value) * 12'd10 + 12'(char_i[3:0]);
  assign acc_sat = (acc > 12'(dqip_pkg::SegSat)) ? dqip_pkg::SegSat : acc[8:0];

  always_comb begin
    nx     = st_i;
    done_o = 1'b0;
    addr_o = 32'd0;
    if (!st_i.error_seen) begin
      if (st_i.octets_done >= dqip_pkg::OctetCount) begin
        nx.error_seen = 1'b1;
      end else begin
        if (!is_dot) begin
          nx.segment_nonempty = 1'b1;
          case (st_i.number_phase)
            dqip_pkg::PhSpace: begin
              if (is_space) begin
                nx.number_phase = dqip_pkg::PhSpace;
              end else if (is_sign) begin
                nx.segment_negative = (char_i == dqip_pkg::CharMinus);
                nx.number_phase     = dqip_pkg::PhDigits;
              end else if (is_digit) begin
                nx.segment_value = acc_sat;
                nx.number_phase  = dqip_pkg::PhDigits;
              end else begin
                nx.number_phase = dqip_pkg::PhStop;
              end
            end
            dqip_pkg::PhDigits: begin
              if (is_digit) begin
                nx.segment_value = acc_sat;
              end else begin
                nx.number_phase = dqip_pkg::PhStop;
              end
            end
            dqip_pkg::PhStop: begin
              nx.number_phase = dqip_pkg::PhStop;
            end
            default: begin
              nx.number_phase = dqip_pkg::PhStop;
            end
          endcase
        end
        if (is_dot || last_i) begin
          if (!nx.segment_nonempty || (nx.segment_value > dqip_pkg::OctetMax) ||
              (nx.segment_negative && (nx.segment_value != 9'd0))) begin
            nx.error_seen = 1'b1;
          end else if (st_i.octets_done < (dqip_pkg::OctetCount - 3'd1)) begin
            nx.octets_so_far = {st_i.octets_so_far[15:0], nx.segment_value[7:0]};
            nx.octets_done   = st_i.octets_done + 3'd1;
          end else begin
            addr_o         = {st_i.octets_so_far, nx.segment_value[7:0]};
            nx.octets_done = st_i.octets_done + 3'd1;
            done_o         = 1'b1;
          end
          nx.segment_value    = 9'd0;
          nx.segment_nonempty = 1'b0;
          nx.number_phase     = dqip_pkg::PhSpace;
          nx.segment_negative = 1'b0;
        end
      end
    end
    // The end of a string always returns the parser to its idle state.
    st_o = last_i ? dqip_pkg::StateReset : nx;
  end

endmodule

// ----- rtl/dotted_quad_ipv4_parser_core.sv -----
`timescale 1ns / 1ps
// Top level of the dotted-quad IPv4 text parser: input register, parser state,
// result register. Depends on dqip_pkg, dqip_in_reg and dqip_step.
//
//   channel | direction | payload              | handshake
//   --------+-----------+----------------------+------------------------------
//   in      | input     | character[7:0], last | in_valid_i / in_stall_o
//   out     | output    | ok, address[31:0]    | out_valid_o / out_stall_i
//
// One character per cycle, unless a final character waits on a stalled, full result
// register. A character is first held in the input register; its parser update and
// any result are then registered into the parser state and the result register.
// Reset (rst_ni low) empties both registers and returns the parser to idle.
// Only a final character waits on a stalled, full result register; other
// characters keep flowing under an output stall.
module dotted_quad_ipv4_parser_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dqip_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dqip_pkg::out_item_t out_data_o
);

  logic                held_valid;
  dqip_pkg::in_item_t  held_data;
  logic                advance;
  logic                emit;
  dqip_pkg::state_t    st_q, st_d;
  logic                done;
  logic [31:0]         addr;
  logic                out_vld_q, out_vld_d;
  dqip_pkg::out_item_t out_q;

  // Input register: holds one transaction until the parser consumes it.
  dqip_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .advance_i    (advance),
    .held_valid_o (held_valid),
    .held_data_o  (held_data)
  );

  // Per-character parser update.
  dqip_step u_step (
    .st_i   (st_q),
    .char_i (held_data.character),
    .last_i (held_data.last),
    .st_o   (st_d),
    .done_o (done),
    .addr_o (addr)
  );

  // Advance whenever there is a character, unless it produces a result and the
  // result register is full and stalled.
  assign advance = held_valid && (!held_data.last || !out_vld_q || !out_stall_i);
  assign emit    = advance && held_data.last;

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= dqip_pkg::StateReset;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        st_q <= st_d;
      end
      out_vld_q <= out_vld_d;
    end
  end

  // Result payload: the address reads as zero unless the string parsed cleanly.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.ok      <= done;
      out_q.address <= done ? addr : 32'd0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // The octet count never exceeds four.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.octets_done <= dqip_pkg::OctetCount)
    else $error("octet count beyond four");

  // A consumed final character leaves the parser idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (st_q == dqip_pkg::StateReset))
    else $error("parser state not cleared after end of string");

  // A failed parse reports a zero address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.ok) |-> (out_q.address == 32'd0))
    else $error("nonzero address on failed parse");

  // A result is never loaded over one that is still stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_vld_q || !out_stall_i))
    else $error("result register overwritten while stalled");

  // Once an error is seen, the segment collection stays frozen until the end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.error_seen && advance && !held_data.last) |=>
      (st_q.error_seen && $stable(st_q.octets_done)))
    else $error("parser state moved after an error");

endmodule
